// ===== sv/ipatc_pkg.sv =====
// Package for the address text classifier: item and verdict types, character
// and limit constants and the character-class helpers. No dependencies.
`default_nettype none

package ipatc_pkg;

   localparam int CharWidth = 8;

   localparam logic [CharWidth-1:0] CHAR_DOT      = 8'h2E;
   localparam logic [CharWidth-1:0] CHAR_COLON    = 8'h3A;
   localparam logic [CharWidth-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE     = 8'h39;
   localparam logic [CharWidth-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_LOWER_F  = 8'h66;
   localparam logic [CharWidth-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_UPPER_F  = 8'h46;

   localparam logic [2:0] V4_DOTS      = 3'd3;
   localparam logic [3:0] V6_COLONS    = 4'd7;
   localparam logic [2:0] V6_GROUP_MAX = 3'd4;
   localparam logic [8:0] OCTET_MAX    = 9'd255;
   localparam logic [8:0] OCTET_SAT    = 9'd256;

   typedef enum logic [1:0] {
      VERDICT_NONE = 2'd0,
      VERDICT_IPV4 = 2'd1,
      VERDICT_IPV6 = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 no_char;
      logic                 last_char;
   } item_type;

   function automatic logic is_digit(input logic [CharWidth-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_hex_letter(input logic [CharWidth-1:0] c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
   endfunction

endpackage

`default_nettype wire

// ===== sv/ipatc_if.sv =====
// Valid/ready channel interfaces for the address text classifier.
// Depends on ipatc_pkg.
`default_nettype none

interface ipatc_req_if;
   import ipatc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] character;
   logic                 no_char;
   logic                 last_char;

   modport source (output valid, output character, output no_char, output last_char,
                   input ready);
   modport sink   (input valid, input character, input no_char, input last_char,
                   output ready);
endinterface

interface ipatc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== sv/ip_address_text_classifier.sv =====
// Address text classifier top level: input word register, scan state and
// verdict register. Depends on ipatc_pkg, ipatc_if and ipatc_scan.
//
// Usage:
//   req_chan carries one character word per handshake (character, no_char,
//   last_char). A word with no_char set carries no character; with last_char
//   set it still closes the string. rsp_chan carries one verdict word per
//   string (0 neither, 1 IPv4, 2 IPv6), produced by the word with last_char.
//   The closing word passes through the input register, and its verdict
//   through the result register, which drives rsp_chan.valid.
//   Throughput: one word per cycle, but a closing word is held while the
//   result register is full; the scan update is combinational between the
//   input register and the result register.
//   Reset clears the scan state and empties both registers; req_chan.ready
//   is high the cycle after reset drops.
//   When the receiver stalls with a verdict pending, non-final words keep
//   flowing; a closing word waits in the input register, holding
//   req_chan.ready low, until the result register frees.
`default_nettype none

module ip_address_text_classifier (
   input  wire logic    clock,
   input  wire logic    reset,
   ipatc_req_if.sink    req_chan,
   ipatc_rsp_if.source  rsp_chan
);
   import ipatc_pkg::*;

   logic        in_valid_ff;
   item_type    in_item_ff;
   logic        out_valid_ff;
   verdict_type out_verdict_ff;
   verdict_type verdict;
   logic        advance;
   logic        take_req;

   // a closing word needs a free result slot; other words always advance
   assign advance  = in_valid_ff &&
                     (!in_item_ff.last_char || !out_valid_ff || rsp_chan.ready);
   assign take_req = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.verdict = out_verdict_ff;

   ipatc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff.character <= req_chan.character;
         in_item_ff.no_char   <= req_chan.no_char;
         in_item_ff.last_char <= req_chan.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last_char) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last_char) begin
         out_verdict_ff <= verdict;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ipatc_scan.sv =====
// Per-string scan state for the address text classifier: counters, current
// group tracking and the two rule flags; forms the verdict. Depends on ipatc_pkg.
`default_nettype none

module ipatc_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire ipatc_pkg::item_type item,
   output ipatc_pkg::verdict_type  verdict
);
   import ipatc_pkg::*;

   logic [2:0]  dot_count_ff,  dot_count_in;
   logic [3:0]  colon_count_ff, colon_count_in;
   logic [2:0]  group_length_ff, group_length_in;
   logic [8:0]  group_value_ff, group_value_in;
   logic        lead_zero_ff, lead_zero_in;
   logic        dotted_ok_ff, dotted_ok_in;
   logic        hex_ok_ff, hex_ok_in;

   logic        c_digit;
   logic        c_hex_letter;
   logic [3:0]  digit_value;
   logic [11:0] scaled_value;

   assign c_digit      = is_digit(item.character);
   assign c_hex_letter = is_hex_letter(item.character);
   assign digit_value  = 4'(item.character - CHAR_ZERO);
   assign scaled_value = 12'(group_value_ff) * 12'd10 + 12'(digit_value);

   // next scan state after this word's character
   always_comb begin
      dot_count_in    = dot_count_ff;
      colon_count_in  = colon_count_ff;
      group_length_in = group_length_ff;
      group_value_in  = group_value_ff;
      lead_zero_in    = lead_zero_ff;
      dotted_ok_in    = dotted_ok_ff;
      hex_ok_in       = hex_ok_ff;
      if (!item.no_char) begin
         if (item.character == CHAR_DOT) begin
            if (group_length_ff == 3'd0) dotted_ok_in = 1'b0;
            hex_ok_in = 1'b0;
            if (dot_count_ff != 3'd7) dot_count_in = dot_count_ff + 3'd1;
            group_length_in = 3'd0;
            group_value_in  = 9'd0;
            lead_zero_in    = 1'b0;
         end else if (item.character == CHAR_COLON) begin
            if (group_length_ff == 3'd0) hex_ok_in = 1'b0;
            dotted_ok_in = 1'b0;
            if (colon_count_ff != 4'd15) colon_count_in = colon_count_ff + 4'd1;
            group_length_in = 3'd0;
            group_value_in  = 9'd0;
            lead_zero_in    = 1'b0;
         end else if (!c_digit && !c_hex_letter) begin
            dotted_ok_in = 1'b0;
            hex_ok_in    = 1'b0;
         end else begin
            if (group_length_ff >= V6_GROUP_MAX) hex_ok_in = 1'b0;
            if (c_digit) begin
               if (group_length_ff == 3'd0) begin
                  lead_zero_in = (digit_value == 4'd0);
               end else if (lead_zero_ff) begin
                  dotted_ok_in = 1'b0;
               end
               // saturate the octet value one past its limit
               if (group_value_ff <= OCTET_MAX) begin
                  if (scaled_value > 12'(OCTET_MAX)) begin
                     dotted_ok_in   = 1'b0;
                     group_value_in = OCTET_SAT;
                  end else begin
                     group_value_in = scaled_value[8:0];
                  end
               end
            end else begin
               dotted_ok_in = 1'b0;
            end
            if (group_length_ff != 3'd7) group_length_in = group_length_ff + 3'd1;
         end
      end

      if (dotted_ok_in && (dot_count_in == V4_DOTS) && (group_length_in != 3'd0)) begin
         verdict = VERDICT_IPV4;
      end else if (hex_ok_in && (colon_count_in == V6_COLONS) &&
                   (group_length_in != 3'd0)) begin
         verdict = VERDICT_IPV6;
      end else begin
         verdict = VERDICT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_char)) begin
         dot_count_ff    <= '0;
         colon_count_ff  <= '0;
         group_length_ff <= '0;
         group_value_ff  <= '0;
         lead_zero_ff    <= 1'b0;
         dotted_ok_ff    <= 1'b1;
         hex_ok_ff       <= 1'b1;
      end else if (step) begin
         dot_count_ff    <= dot_count_in;
         colon_count_ff  <= colon_count_in;
         group_length_ff <= group_length_in;
         group_value_ff  <= group_value_in;
         lead_zero_ff    <= lead_zero_in;
         dotted_ok_ff    <= dotted_ok_in;
         hex_ok_ff       <= hex_ok_in;
      end
   end

endmodule

`default_nettype wire
